// ===== rtl/core/atan2ct_pkg.sv =====
// atan2ct_pkg: shared constants, types and the arctangent table for atan2_cubic_table.
// No dependencies; the table is built at elaboration from a fixed-point CORDIC.
`timescale 1ns / 1ps

package atan2ct_pkg;

    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int TBL_BITS   = 6;
    localparam int TABLE_SIZE = 1 << TBL_BITS;
    localparam int ROM_DEPTH  = TABLE_SIZE + 4;
    localparam int IDX_W      = $clog2(ROM_DEPTH);
    localparam int ROM_W      = 18;

    localparam int CORDIC_STEPS = 28;
    localparam longint CORDIC_ANGLE [CORDIC_STEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007
    };

    localparam longint HALF_PI_Q32 = 64'd6746518852;
    localparam longint PI_Q32      = 64'd13493037705;
    localparam int     ANGLE_LIMIT = 25736;

    typedef logic signed [ROM_W-1:0] t_rom [ROM_DEPTH];

    typedef struct packed {
        logic swapped;
        logic xneg;
        logic yneg;
        logic zero;
    } t_side;

    // atan((k-1)/TABLE_SIZE) in Q1.16, vectoring cordic then round half away from zero
    function automatic logic signed [ROM_W-1:0] rom_value(input int k);
        longint m;
        longint mag;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint zr;
        int     i;
        m   = longint'(k) - 1;
        mag = (m < 0) ? -m : m;
        x   = longint'(TABLE_SIZE) <<< 36;
        y   = mag <<< 36;
        z   = 0;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x = x + dy;
                y = y - dx;
                z = z + CORDIC_ANGLE[i];
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - CORDIC_ANGLE[i];
            end
        end
        zr = (z >= 0) ? ((z + 8192) >>> 14) : -((8192 - z) >>> 14);
        if (m < 0) begin
            zr = -zr;
        end
        return zr[ROM_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom tbl;
        int   k;
        for (k = 0; k < ROM_DEPTH; k++) begin
            tbl[k] = rom_value(k);
        end
        return tbl;
    endfunction

    localparam t_rom ATAN_ROM = build_rom();

endpackage

// ===== rtl/core/atan2_cubic_table.sv =====
// atan2_cubic_table: four-quadrant arctangent, one I/Q pair per clock unless stalled, 17-stage pipeline.
// Depends on atan2ct_pkg for the arctangent table, the angle constants and the side-info type.
//
// Takes signed 16-bit (x, y) and returns atan2(y, x) as signed Q3.13 radians within
// +-25736. A new pair is taken every clock while the output is not stalled. The depth
// comes from the 16-step restoring divider (4 steps a stage), the table interpolation
// multipliers and the reciprocal multiply for the divide by three (2 stages).
// A stall on the output freezes the whole pipeline; o_stall is high only then.
`timescale 1ns / 1ps

module atan2_cubic_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [atan2ct_pkg::IN_W-1:0] i_x_in,
    input  logic signed [atan2ct_pkg::IN_W-1:0] i_y_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [atan2ct_pkg::OUT_W-1:0] o_angle
);
    import atan2ct_pkg::*;

    localparam int NST      = 17;
    localparam int MAG_W    = IN_W + 1;
    localparam int FR_W     = 16;
    localparam int DIV_ST   = 4;
    localparam int DIV_STEP = FR_W / DIV_ST;
    localparam int W_W      = 40;
    localparam int P_W      = 58;
    localparam int Q_W      = 34;
    localparam int D3_H     = Q_W / 2;
    localparam int D3_M_W   = 35;
    localparam int D3_SH    = 36;
    localparam int T_W      = 44;
    localparam int R_W      = T_W - 19;

    localparam logic signed [W_W-1:0] SIX_Q32  = W_W'(64'd6 << 32);
    localparam logic signed [T_W-1:0] HALF_PI  = T_W'(HALF_PI_Q32);
    localparam logic signed [T_W-1:0] PI_VAL   = T_W'(PI_Q32);
    localparam logic [P_W-1:0]        S_ROUND  = P_W'(196608);
    localparam logic [T_W-1:0]        T_ROUND  = T_W'(1 << 18);
    localparam logic [R_W-1:0]        R_LIMIT  = R_W'(ANGLE_LIMIT);
    // ceil(2^36 / 3), exact floor division for operands below 2^35
    localparam logic [D3_M_W-1:0]     D3_RECIP = 35'd22906492246;
    localparam logic signed [OUT_W-1:0] A_MAX  = OUT_W'(ANGLE_LIMIT);

    logic            en;
    logic [NST-1:0]  r_vld;
    t_side           r_side [NST];

    assign en      = !(r_vld[NST-1] && i_stall);
    assign o_stall = r_vld[NST-1] && i_stall;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 0: magnitudes, order, first quotient bit
    logic signed [MAG_W-1:0] sx;
    logic signed [MAG_W-1:0] sy;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;
    logic                    n_swap;
    logic [MAG_W-1:0]        n_num;
    logic [MAG_W-1:0]        n_den;
    logic                    n_q16;
    t_side                   n_side;

    logic [MAG_W-1:0] r_drem [DIV_ST+1];
    logic [MAG_W-1:0] r_dden [DIV_ST+1];
    logic [FR_W:0]    r_dq   [DIV_ST+1];

    always_comb begin
        sx     = {i_x_in[IN_W-1], i_x_in};
        sy     = {i_y_in[IN_W-1], i_y_in};
        ax     = sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
        ay     = sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
        n_swap = ax < ay;
        n_num  = n_swap ? ax : ay;
        n_den  = n_swap ? ay : ax;
        n_q16  = (n_num == n_den) && (n_den != '0);
        n_side.swapped = n_swap;
        n_side.xneg    = i_x_in[IN_W-1];
        n_side.yneg    = i_y_in[IN_W-1];
        n_side.zero    = (n_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            r_dden[0] <= n_den;
            r_drem[0] <= n_q16 ? '0 : n_num;
            r_dq[0]   <= {{FR_W{1'b0}}, n_q16};
            for (int j = 1; j < NST; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // stages 1..4: restoring divider, four quotient bits a stage
    for (genvar g = 1; g <= DIV_ST; g++) begin : g_div
        logic [MAG_W-1:0] n_rem;
        logic [FR_W:0]    n_q;
        logic [MAG_W:0]   rem2;
        always_comb begin
            n_rem = r_drem[g-1];
            n_q   = r_dq[g-1];
            rem2  = '0;
            for (int s = 0; s < DIV_STEP; s++) begin
                rem2 = {n_rem, 1'b0};
                if (rem2 >= {1'b0, r_dden[g-1]}) begin
                    n_rem = MAG_W'(rem2 - {1'b0, r_dden[g-1]});
                    n_q   = {n_q[FR_W-1:0], 1'b1};
                end else begin
                    n_rem = MAG_W'(rem2);
                    n_q   = {n_q[FR_W-1:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_drem[g] <= n_rem;
                r_dden[g] <= r_dden[g-1];
                r_dq[g]   <= n_q;
            end
        end
    end

    // stage 5: table index, fraction, table reads, f squared
    logic [FR_W:0]      ratio;
    logic [IDX_W-1:0]   idx;
    logic [FR_W-1:0]    frac;
    logic [FR_W-1:0]    r_f5;
    logic [2*FR_W-1:0]  r_f2_5;
    logic signed [ROM_W-1:0] r_ra5;
    logic signed [ROM_W-1:0] r_rb5;
    logic signed [ROM_W-1:0] r_rc5;
    logic signed [ROM_W-1:0] r_rd5;

    always_comb begin
        ratio = r_side[DIV_ST].zero ? '0 : r_dq[DIV_ST];
        idx   = IDX_W'(ratio >> (FR_W - TBL_BITS));
        frac  = FR_W'(ratio << TBL_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f5   <= frac;
            r_f2_5 <= frac * frac;
            r_ra5  <= ATAN_ROM[idx];
            r_rb5  <= ATAN_ROM[IDX_W'(idx + IDX_W'(1))];
            r_rc5  <= ATAN_ROM[IDX_W'(idx + IDX_W'(2))];
            r_rd5  <= ATAN_ROM[IDX_W'(idx + IDX_W'(3))];
        end
    end

    // stage 6: f cubed
    logic [3*FR_W-1:0]  f3_full;
    logic [FR_W-1:0]    r_f6;
    logic [2*FR_W-1:0]  r_f2_6;
    logic [2*FR_W-1:0]  r_f3_6;
    logic signed [ROM_W-1:0] r_ra6;
    logic signed [ROM_W-1:0] r_rb6;
    logic signed [ROM_W-1:0] r_rc6;
    logic signed [ROM_W-1:0] r_rd6;

    assign f3_full = r_f2_5 * r_f5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f6   <= r_f5;
            r_f2_6 <= r_f2_5;
            r_f3_6 <= f3_full[3*FR_W-1:FR_W];
            r_ra6  <= r_ra5;
            r_rb6  <= r_rb5;
            r_rc6  <= r_rc5;
            r_rd6  <= r_rd5;
        end
    end

    // stage 7: lagrange weights times six, Q.32
    logic signed [W_W-1:0] F1;
    logic signed [W_W-1:0] F2;
    logic signed [W_W-1:0] F3;
    logic signed [W_W-1:0] r_wa7;
    logic signed [W_W-1:0] r_wb7;
    logic signed [W_W-1:0] r_wc7;
    logic signed [W_W-1:0] r_wd7;
    logic signed [ROM_W-1:0] r_ra7;
    logic signed [ROM_W-1:0] r_rb7;
    logic signed [ROM_W-1:0] r_rc7;
    logic signed [ROM_W-1:0] r_rd7;

    always_comb begin
        F1 = $signed({{(W_W-2*FR_W){1'b0}}, r_f6, {FR_W{1'b0}}});
        F2 = $signed({{(W_W-2*FR_W){1'b0}}, r_f2_6});
        F3 = $signed({{(W_W-2*FR_W){1'b0}}, r_f3_6});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wa7 <= -F3 - (F1 <<< 1) + (F2 <<< 1) + F2;
            r_wb7 <= (F3 <<< 1) + F3 - (F2 <<< 2) - (F2 <<< 1) - (F1 <<< 1) - F1 + SIX_Q32;
            r_wc7 <= (F2 <<< 1) + F2 - (F3 <<< 1) - F3 + (F1 <<< 2) + (F1 <<< 1);
            r_wd7 <= F3 - F1;
            r_ra7 <= r_ra6;
            r_rb7 <= r_rb6;
            r_rc7 <= r_rc6;
            r_rd7 <= r_rd6;
        end
    end

    // stage 8: weighted taps
    logic signed [P_W-1:0] r_pa8;
    logic signed [P_W-1:0] r_pb8;
    logic signed [P_W-1:0] r_pc8;
    logic signed [P_W-1:0] r_pd8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa8 <= r_ra7 * r_wa7;
            r_pb8 <= r_rb7 * r_wb7;
            r_pc8 <= r_rc7 * r_wc7;
            r_pd8 <= r_rd7 * r_wd7;
        end
    end

    // stages 9, 10: sum
    logic signed [P_W-1:0] r_sab9;
    logic signed [P_W-1:0] r_scd9;
    logic signed [P_W-1:0] r_s10;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sab9 <= r_pa8 + r_pb8;
            r_scd9 <= r_pc8 + r_pd8;
            r_s10  <= r_sab9 + r_scd9;
        end
    end

    // stage 11: magnitude, round, drop the power-of-two part of the divide by six
    // the rounded magnitude stays below 2^34
    logic [P_W-1:0] s_abs;
    logic [P_W-1:0] s_rnd;
    logic [Q_W-1:0] r_w11;
    logic           r_sneg11;

    always_comb begin
        s_abs = r_s10[P_W-1] ? P_W'(-r_s10) : P_W'(r_s10);
        s_rnd = (s_abs + S_ROUND) >> 17;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w11    <= Q_W'(s_rnd);
            r_sneg11 <= r_s10[P_W-1];
        end
    end

    // stage 12: divide by three via the reciprocal, split into two half-width products
    logic [D3_H-1:0]        w_lo;
    logic [D3_H-1:0]        w_hi;
    logic [D3_H+D3_M_W-1:0] r_plo12;
    logic [D3_H+D3_M_W-1:0] r_phi12;
    logic                   r_sneg12;

    assign w_lo = r_w11[D3_H-1:0];
    assign w_hi = r_w11[Q_W-1:D3_H];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plo12  <= w_lo * D3_RECIP;
            r_phi12  <= w_hi * D3_RECIP;
            r_sneg12 <= r_sneg11;
        end
    end

    // stage 13: combine the products and keep the quotient
    logic [2*D3_H+D3_M_W-1:0] d3_prod;
    logic [Q_W-1:0]           r_q13;
    logic                     r_sneg13;

    assign d3_prod = {r_phi12, {D3_H{1'b0}}} + {{D3_H{1'b0}}, r_plo12};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q13    <= Q_W'(d3_prod >> D3_SH);
            r_sneg13 <= r_sneg12;
        end
    end

    // stage 14: sign back, octant fold
    logic signed [T_W-1:0] tq;
    logic signed [T_W-1:0] r_t14;

    always_comb begin
        tq = $signed({{(T_W-Q_W){1'b0}}, r_q13});
        if (r_sneg13) begin
            tq = -tq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t14 <= r_side[13].swapped ? HALF_PI - tq : tq;
        end
    end

    // stage 15: quadrant corrections
    logic signed [T_W-1:0] t2;
    logic signed [T_W-1:0] r_t15;

    assign t2 = r_side[14].xneg ? PI_VAL - r_t14 : r_t14;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t15 <= r_side[14].yneg ? -t2 : t2;
        end
    end

    // stage 16: round to Q3.13 and clamp
    logic [T_W-1:0]        t_abs;
    logic [T_W-1:0]        t_sh;
    logic [R_W-1:0]        t_mag;
    logic [R_W-1:0]        t_sat;
    logic signed [OUT_W-1:0] r_angle;

    always_comb begin
        t_abs = r_t15[T_W-1] ? T_W'(-r_t15) : T_W'(r_t15);
        t_sh  = (t_abs + T_ROUND) >> 19;
        t_mag = R_W'(t_sh);
        t_sat = (t_mag > R_LIMIT) ? R_LIMIT : t_mag;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_angle <= r_t15[T_W-1] ? -$signed(OUT_W'(t_sat)) : $signed(OUT_W'(t_sat));
        end
    end

    assign o_angle = r_angle;

`ifndef SYNTHESIS
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= A_MAX) && (o_angle >= -A_MAX))
        else $error("angle out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction lost at entry");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== sim/atan2_cubic_table_tb.sv =====
// atan2_cubic_table_tb: self-checking bench for the four-quadrant arctangent pipeline.
// Depends on atan2ct_pkg for widths and the cordic angle steps; predicts each angle on its own.
`timescale 1ns / 1ps

module atan2_cubic_table_tb;
    import atan2ct_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int RAND_ITEMS  = 1200;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [IN_W-1:0]  i_x_in = '0;
    logic signed [IN_W-1:0]  i_y_in = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [OUT_W-1:0] o_angle;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int          fail_count = 0;
    int          cycles = 0;

    atan2_cubic_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_x_in  (i_x_in),
        .i_y_in  (i_y_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_angle (o_angle)
    );

    always #CLK_HALF i_clk = ~i_clk;

    class angle_scoreboard;
        longint atan_tbl [ROM_DEPTH];
        logic signed [OUT_W-1:0] pending_angles [$];

        function new();
            for (int k = 0; k < ROM_DEPTH; k++) begin
                atan_tbl[k] = table_entry(k);
            end
        endfunction

        static function longint round_div(longint v, longint d);
            if (v >= 0) begin
                return (v + d / 2) / d;
            end
            return -((-v + d / 2) / d);
        endfunction

        // atan((k-1)/64) in Q1.16 by vectoring cordic
        static function longint table_entry(int k);
            longint m;
            longint mag;
            longint cx;
            longint cy;
            longint acc;
            longint sx;
            longint sy;
            m   = longint'(k) - 1;
            mag = (m < 0) ? -m : m;
            cx  = longint'(TABLE_SIZE) <<< 36;
            cy  = mag <<< 36;
            acc = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                sx = cx >>> i;
                sy = cy >>> i;
                if (cy >= 0) begin
                    cx  = cx + sy;
                    cy  = cy - sx;
                    acc = acc + CORDIC_ANGLE[i];
                end else begin
                    cx  = cx - sy;
                    cy  = cy + sx;
                    acc = acc - CORDIC_ANGLE[i];
                end
            end
            acc = round_div(acc, 16384);
            return (m < 0) ? -acc : acc;
        endfunction

        function logic signed [OUT_W-1:0] predict_angle(logic signed [IN_W-1:0] xv,
                                                         logic signed [IN_W-1:0] yv);
            longint ax;
            longint ay;
            longint ratio;
            longint pos;
            longint idx;
            longint f;
            longint f1;
            longint f2;
            longint f3;
            longint wa;
            longint wb;
            longint wc;
            longint wd;
            longint acc;
            longint t;
            bit     swapped;
            ax = (xv < 0) ? -longint'(xv) : longint'(xv);
            ay = (yv < 0) ? -longint'(yv) : longint'(yv);
            swapped = 1'b0;
            if (ax < ay) begin
                ratio   = (ax <<< 16) / ay;
                swapped = 1'b1;
            end else if (ax > 0) begin
                ratio = (ay <<< 16) / ax;
            end else begin
                ratio = 0;
            end
            pos = ratio * TABLE_SIZE;
            idx = pos >>> 16;
            f   = pos & 64'hFFFF;
            f1  = f <<< 16;
            f2  = f * f;
            f3  = (f2 * f) >>> 16;
            // lagrange weights scaled by six
            wa  = -f3 - 2 * f1 + 3 * f2;
            wb  = 3 * f3 - 6 * f2 - 3 * f1 + (longint'(6) <<< 32);
            wc  = -3 * f3 + 3 * f2 + 6 * f1;
            wd  = f3 - f1;
            acc = atan_tbl[idx] * wa + atan_tbl[idx+1] * wb
                + atan_tbl[idx+2] * wc + atan_tbl[idx+3] * wd;
            t = round_div(acc, longint'(6) <<< 16);
            if (swapped) t = HALF_PI_Q32 - t;
            if (xv < 0) t = PI_Q32 - t;
            if (yv < 0) t = -t;
            t = round_div(t, longint'(1) <<< 19);
            if (t > ANGLE_LIMIT) t = ANGLE_LIMIT;
            if (t < -ANGLE_LIMIT) t = -ANGLE_LIMIT;
            return t[OUT_W-1:0];
        endfunction

        function void note_pair(logic signed [IN_W-1:0] xv, logic signed [IN_W-1:0] yv);
            pending_angles.push_back(predict_angle(xv, yv));
        endfunction

        // empty string when the angle matches
        function string check_angle(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (pending_angles.size() == 0) begin
                return $sformatf("angle %0d with nothing pending", got);
            end
            want = pending_angles.pop_front();
            if (got !== want) begin
                return $sformatf("angle got %0d want %0d", got, want);
            end
            return "";
        endfunction
    endclass

    angle_scoreboard sb = new();

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic send_pair(logic signed [IN_W-1:0] xv, logic signed [IN_W-1:0] yv);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_x_in  = xv;
        i_y_in  = yv;
        do @(posedge i_clk); while (o_stall);
        sb.note_pair(xv, yv);
        @(negedge i_clk);
    endtask

    task automatic drain_pending();
        i_valid = 1'b0;
        while (sb.pending_angles.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        logic signed [IN_W-1:0] xv;
        logic signed [IN_W-1:0] yv;
        int unsigned            kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(3);
            xv   = IN_W'($urandom);
            yv   = IN_W'($urandom);
            case (kind)
                1: begin
                    xv = IN_W'($signed($urandom_range(64)) - 32);
                    yv = IN_W'($signed($urandom_range(64)) - 32);
                end
                2: begin
                    // near-equal magnitudes exercise the top table entries
                    yv = ($urandom_range(1)) ? xv : -xv;
                    yv = IN_W'(yv + $signed($urandom_range(4)) - 2);
                end
                3: begin
                    if ($urandom_range(1)) xv = IN_W'($signed($urandom_range(6)) - 3);
                    else yv = IN_W'($signed($urandom_range(6)) - 3);
                end
                default: begin
                end
            endcase
            send_pair(xv, yv);
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            msg = sb.check_angle(o_angle);
            if (msg != "") report_mismatch(msg);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // corners: zero, full scale, axes, diagonals, negative x on the axis
        send_pair(0, 0);
        send_pair(-32768, -32768);
        send_pair(32767, -32768);
        send_pair(-32768, 32767);
        send_pair(32767, 32767);
        send_pair(0, -32768);
        send_pair(-32768, 0);
        send_pair(-5, 0);
        send_pair(-1, 0);
        send_pair(1, 0);
        send_pair(0, 1);
        send_pair(0, -1);
        send_pair(-1, -1);
        send_pair(1, -1);
        send_pair(-1, 1);
        send_pair(1, 32767);
        send_pair(32767, 1);
        send_pair(-32767, -1);
        send_pair(-1, -32768);
        send_pair(1234, -1234);
        send_pair(-16384, 16385);

        idle_pct = 0;  stall_pct = 0;  send_random(RAND_ITEMS / 4);
        drain_pending();
        idle_pct = 53; stall_pct = 0;  send_random(RAND_ITEMS / 4);
        idle_pct = 0;  stall_pct = 53; send_random(RAND_ITEMS / 4);
        drain_pending();
        idle_pct = 12; stall_pct = 12; send_random(RAND_ITEMS / 4);

        drain_pending();
        stall_pct = 0;
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (sb.pending_angles.size() != 0) begin
            report_mismatch("expected angles left over");
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
